// ----- rtl/bus_write_value_compressor_defines.svh -----
// Assertion macros used by the verification file of the write-value compressor.
// Depends on nothing; the user must have clk and rst_n in scope.
`ifndef BUS_WRITE_VALUE_COMPRESSOR_DEFINES_SVH
`define BUS_WRITE_VALUE_COMPRESSOR_DEFINES_SVH

// Checked only while out of reset.
`define BWVC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BWVC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bwvc_pkg.sv -----
// Shared types and constants of the write-value compressor.
// Depends on nothing; used by every module of the block.
package bwvc_pkg;

    localparam int WORD_W                = 32;
    localparam int BYTE_W                = 7;
    localparam int DIST_CODE_W           = 9;
    localparam int MAX_BYTES             = 5;
    localparam int BYTE_CNT_W            = 3;
    localparam int DEFAULT_HISTORY_DEPTH = 512;

    // Leading byte patterns of the codeword kinds.
    localparam logic [BYTE_W-1:0] BYTE_NEAR   = 7'h30;
    localparam logic [BYTE_W-1:0] BYTE_FAR    = 7'h34;
    localparam logic [BYTE_W-1:0] BYTE_SMALL  = 7'h38;
    localparam logic [BYTE_W-1:0] BYTE_MEDIUM = 7'h3c;
    localparam logic [BYTE_W-1:0] BYTE_FULL   = 7'h20;

    // Signed range tests done as offset unsigned compares.
    localparam logic [WORD_W-1:0] SMALL_OFFSET  = 32'd256;
    localparam logic [WORD_W-1:0] MEDIUM_OFFSET = 32'd32768;
    localparam int                SMALL_BITS    = 9;
    localparam int                MEDIUM_BITS   = 16;

    typedef struct packed {
        logic                   hit;
        logic [DIST_CODE_W-1:0] dist_m1;
        logic [WORD_W-1:0]      word;
    } enc_req_t;

endpackage

// ----- rtl/bwvc_hist.sv -----
// History ring of the write-value compressor: word memory, write pointer, wrap flag.
// Depends on bwvc_pkg.
module bwvc_hist #(
    parameter int HISTORY_DEPTH = bwvc_pkg::DEFAULT_HISTORY_DEPTH,
    parameter int PTR_W         = $clog2(HISTORY_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bwvc_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [PTR_W-1:0]            rd_addr,
    output logic [bwvc_pkg::WORD_W-1:0] rd_data,
    output logic [PTR_W-1:0]            ptr,
    output logic                        full
);

    logic [bwvc_pkg::WORD_W-1:0] mem [HISTORY_DEPTH];
    logic [bwvc_pkg::WORD_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]            ptr_reg;
    logic [PTR_W-1:0]            ptr_next;
    logic                        full_reg;
    logic                        full_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        ptr_next  = ptr_reg;
        full_next = full_reg;
        if (wr_en)
        begin
            if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
            begin
                ptr_next  = '0;
                full_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            full_reg <= full_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign ptr     = ptr_reg;
    assign full    = full_reg;

endmodule

// ----- rtl/bwvc_encoder.sv -----
// Codeword builder and byte serializer with the output register.
// Depends on bwvc_pkg.
module bwvc_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  bwvc_pkg::enc_req_t          req,
    output logic                        ready,
    output logic                        push,
    output logic [bwvc_pkg::BYTE_W-1:0] code_byte,
    output logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int BW = bwvc_pkg::BYTE_W;
    localparam int CW = bwvc_pkg::BYTE_CNT_W;

    logic [BW-1:0]               byte_reg  [bwvc_pkg::MAX_BYTES];
    logic [BW-1:0]               byte_next [bwvc_pkg::MAX_BYTES];
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic [bwvc_pkg::WORD_W-1:0] small_up;
    logic [bwvc_pkg::WORD_W-1:0] medium_up;
    logic                        is_small;
    logic                        is_medium;
    logic [bwvc_pkg::WORD_W-1:0] v;
    logic [bwvc_pkg::DIST_CODE_W-1:0] d;

    assign v         = req.word;
    assign d         = req.dist_m1;
    assign small_up  = v + bwvc_pkg::SMALL_OFFSET;
    assign medium_up = v + bwvc_pkg::MEDIUM_OFFSET;
    assign is_small  = (small_up[bwvc_pkg::WORD_W-1:bwvc_pkg::SMALL_BITS] == '0);
    assign is_medium = (medium_up[bwvc_pkg::WORD_W-1:bwvc_pkg::MEDIUM_BITS] == '0);

    // Only a stored kind (medium or full, no hit) enters the history ring.
    assign push = start && !req.hit && !is_small;

    always_comb
    begin
        for (int i = 0; i < bwvc_pkg::MAX_BYTES; i++)
        begin
            byte_next[i] = byte_reg[i];
        end
        cnt_next = cnt_reg;
        if (start)
        begin
            if (req.hit && (d < bwvc_pkg::DIST_CODE_W'(4)))
            begin
                byte_next[0] = bwvc_pkg::BYTE_NEAR | BW'(d[1:0]);
                cnt_next     = CW'(1);
            end
            else if (req.hit)
            begin
                byte_next[0] = bwvc_pkg::BYTE_FAR | BW'(d[8:7]);
                byte_next[1] = d[6:0];
                cnt_next     = CW'(2);
            end
            else if (is_small)
            begin
                byte_next[0] = bwvc_pkg::BYTE_SMALL | BW'(v[8:7]);
                byte_next[1] = v[6:0];
                cnt_next     = CW'(2);
            end
            else if (is_medium)
            begin
                byte_next[0] = bwvc_pkg::BYTE_MEDIUM | BW'(v[15:14]);
                byte_next[1] = v[13:7];
                byte_next[2] = v[6:0];
                cnt_next     = CW'(3);
            end
            else
            begin
                byte_next[0] = bwvc_pkg::BYTE_FULL | BW'(v[31:28]);
                byte_next[1] = v[27:21];
                byte_next[2] = v[20:14];
                byte_next[3] = v[13:7];
                byte_next[4] = v[6:0];
                cnt_next     = CW'(5);
            end
        end
        else if (out_valid && out_ready)
        begin
            for (int i = 0; i < bwvc_pkg::MAX_BYTES - 1; i++)
            begin
                byte_next[i] = byte_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bwvc_pkg::MAX_BYTES; i++)
        begin
            byte_reg[i] <= byte_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign ready     = (cnt_reg == '0);
    assign out_valid = (cnt_reg != '0);
    assign last_byte = (cnt_reg == CW'(1));
    assign code_byte = byte_reg[0];

endmodule

// ----- rtl/bus_write_value_compressor.sv -----
// Write-value compressor: each accepted 32-bit word becomes a codeword of one to five 7-bit
// bytes, the last one marked by last_byte. The word is first looked up in a ring of earlier
// stored words, most recent first, one entry per cycle through the single read port of the
// history memory, before its codeword is loaded into the output serializer. The search stops
// at the first hit, at the oldest written entry, or, once the ring is full, after the
// HISTORY_DEPTH - 1 most recent entries. The next word is accepted while the previous
// codeword still drains, and its codeword waits until the serializer is empty. No clearing
// pass is needed after reset.
module bus_write_value_compressor #(
    parameter int HISTORY_DEPTH = bwvc_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bwvc_pkg::WORD_W-1:0] word_value,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic [bwvc_pkg::BYTE_W-1:0] code_byte,
    output logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_HAND   = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [bwvc_pkg::WORD_W-1:0] word_reg;
    logic [bwvc_pkg::WORD_W-1:0] word_next;
    logic [CNT_W-1:0]            j_reg;
    logic [CNT_W-1:0]            j_next;
    logic [PTR_W-1:0]            addr_reg;
    logic [PTR_W-1:0]            addr_next;
    logic                        vld_reg;
    logic                        vld_next;
    logic [PTR_W-1:0]            cmp_dist_reg;
    logic [PTR_W-1:0]            cmp_dist_next;
    logic                        hit_reg;
    logic                        hit_next;
    logic [PTR_W-1:0]            dist_reg;
    logic [PTR_W-1:0]            dist_next;

    logic                        rd_en;
    logic [bwvc_pkg::WORD_W-1:0] rd_data;
    logic [PTR_W-1:0]            ptr;
    logic                        full;
    logic [CNT_W-1:0]            limit;
    logic                        enc_start;
    logic                        enc_ready;
    logic                        push;
    bwvc_pkg::enc_req_t          enc_req;

    assign in_ready  = (state_reg == S_IDLE);
    assign limit     = full ? CNT_W'(HISTORY_DEPTH - 1) : CNT_W'(ptr);
    assign enc_start = (state_reg == S_HAND) && enc_ready;

    assign enc_req.hit     = hit_reg;
    assign enc_req.dist_m1 = bwvc_pkg::DIST_CODE_W'(dist_reg)
                             - bwvc_pkg::DIST_CODE_W'(1);
    assign enc_req.word    = word_reg;

    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        j_next        = j_reg;
        addr_next     = addr_reg;
        vld_next      = 1'b0;
        cmp_dist_next = cmp_dist_reg;
        hit_next      = hit_reg;
        dist_next     = dist_reg;
        rd_en         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = word_value;
                    j_next     = CNT_W'(1);
                    addr_next  = (ptr == '0) ? PTR_W'(HISTORY_DEPTH - 1) : ptr - 1'b1;
                    hit_next   = 1'b0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // The entry read last cycle is compared while the next one is fetched.
                if (vld_reg && (rd_data == word_reg))
                begin
                    hit_next   = 1'b1;
                    dist_next  = cmp_dist_reg;
                    state_next = S_HAND;
                end
                else if (j_reg <= limit)
                begin
                    rd_en         = 1'b1;
                    vld_next      = 1'b1;
                    cmp_dist_next = PTR_W'(j_reg);
                    j_next        = j_reg + 1'b1;
                    addr_next     = (addr_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1)
                                                     : addr_reg - 1'b1;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_HAND;
                end
            end
            S_HAND:
            begin
                if (enc_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        j_reg        <= j_next;
        addr_reg     <= addr_next;
        cmp_dist_reg <= cmp_dist_next;
        hit_reg      <= hit_next;
        dist_reg     <= dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    bwvc_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PTR_W         (PTR_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (word_reg),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data),
        .ptr     (ptr),
        .full    (full)
    );

    bwvc_encoder u_encoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (enc_start),
        .req       (enc_req),
        .ready     (enc_ready),
        .push      (push),
        .code_byte (code_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

// ----- rtl/bwvc_checker.sv -----
// Port-level checks of the write-value compressor and the bind that attaches them.
// Depends on bus_write_value_compressor_defines.svh and bwvc_pkg.
`include "bus_write_value_compressor_defines.svh"

module bwvc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [bwvc_pkg::BYTE_W-1:0] code_byte,
    input logic                        last_byte,
    input logic                        out_valid,
    input logic                        out_ready
);

    // A stalled output transaction keeps its byte.
    `BWVC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(code_byte) && $stable(last_byte), "output byte changed while stalled")

    // Every word needs at least a search cycle and a hand-off cycle.
    `BWVC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready ##1 !in_ready, "input accepted again too early")

    // Once reset has been seen at an edge, nothing is offered at the next one.
    `BWVC_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |=> !out_valid, "output valid during reset")

endmodule

bind bus_write_value_compressor bwvc_checker u_bwvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_byte (code_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
